>>> rtl/core/multichannel_sliding_rms_defines.svh
// Assertion macros shared by the sliding RMS RTL.
`ifndef MULTICHANNEL_SLIDING_RMS_DEFINES_SVH
`define MULTICHANNEL_SLIDING_RMS_DEFINES_SVH

// Consequent must hold at the same edge as the antecedent.
`define MSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define MSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition must never be seen.
`define MSR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/core/msr_pkg.sv
// Types and constants of the multichannel sliding RMS block.
`default_nettype none

package msr_pkg;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_CHANNELS_IN_USE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_STRIDE_LEN      = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WINDOWS     = 2'd2;

	localparam logic [3:0]  CHANNELS_IN_USE_RESET = 4'd8;
	localparam logic [10:0] STRIDE_LEN_RESET      = 11'd16;
	localparam logic [15:0] MAX_WINDOWS_RESET     = 16'hFFFF;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [2:0]        channel;
		logic signed [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [15:0] window_index;
		logic [2:0]  channel_res;
		logic [15:0] rms;
		logic        last_channel;
	} out_item_t;

	// Bookkeeping that rides with a sum of squares through the job queue
	typedef struct packed {
		logic [15:0] window_index;
		logic [2:0]  channel_res;
		logic        last_channel;
	} job_hdr_t;

	typedef struct packed {
		logic [3:0]  channels_in_use;
		logic [10:0] stride_len;
		logic [15:0] max_windows;
	} cfg_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_READ,
		FE_SQUARE,
		FE_SUB,
		FE_ADD,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_DIV,
		BE_SQRT,
		BE_DONE
	} be_state_t;

endpackage

`default_nettype wire

>>> rtl/core/msr_fifo.sv
// Two-entry job queue between the sample front end and the RMS back end.
`default_nettype none

module msr_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/msr_front.sv
// Front end: takes samples, keeps the rings, running sums and frame counters, queues RMS jobs.
`default_nettype none
`include "multichannel_sliding_rms_defines.svh"

module msr_front #(
	parameter int WINDOW_LEN = 64,
	parameter int CHANNELS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  msr_pkg::in_item_t              in_item,
	input  msr_pkg::cfg_t                  cfg,
	input  logic                           job_full,
	output logic                           job_push,
	output msr_pkg::job_hdr_t              job_hdr,
	output logic [$clog2(WINDOW_LEN)+30:0] job_sum
);

	import msr_pkg::*;

	localparam int HEAD_W   = $clog2(WINDOW_LEN);
	localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W    = HEAD_W + 31;
	localparam int DEPTH    = CHANNELS * WINDOW_LEN;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NCH_W    = 5;
	localparam int PHASE_W  = 10;
	localparam int STRIDE_W = 11;

	localparam logic [SUM_W-1:0]    SUM_CAP    = SUM_W'(WINDOW_LEN) << 30;
	localparam logic [NCH_W-1:0]    NCH_MAX    = NCH_W'(CHANNELS);
	localparam logic [STRIDE_W-1:0] STRIDE_MAX = 11'd1024;

	fe_state_t state_q, state_d;

	logic [NCH_W-1:0]    nch_eff;
	logic [STRIDE_W-1:0] stride_eff;
	logic                accept;
	logic                ch_ok;
	logic                is_last;
	logic [ADDR_W-1:0]   slot_d;

	logic [2:0]          ch_q;
	logic                last_q;
	logic [ADDR_W-1:0]   slot_q;
	logic signed [15:0]  sample_q;
	logic signed [15:0]  rd_q;
	logic [30:0]         newsq_q;
	logic [30:0]         oldsq_q;
	logic signed [31:0]  new_prod;
	logic signed [31:0]  old_prod;
	logic [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]    cur_sum;
	logic [SUM_W-1:0]    old_ext;
	logic [SUM_W-1:0]    add_sum;
	logic [CIDX_W-1:0]   ch_idx;

	logic [SUM_W-1:0]    sq_sum_q [CHANNELS];
	logic [HEAD_W-1:0]   head_q;
	logic [FILL_W-1:0]   fill_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [15:0]         we_q;

	logic                window_frame;
	logic                full_win;
	logic                emit;
	logic                proceed;
	logic [PHASE_W:0]    phase_inc;

	logic signed [15:0]  ring_mem [DEPTH];

	// Register values out of range are clamped
	always_comb begin
		priority if (cfg.channels_in_use == 4'd0) begin
			nch_eff = NCH_W'(1);
		end else if (NCH_W'(cfg.channels_in_use) > NCH_MAX) begin
			nch_eff = NCH_MAX;
		end else begin
			nch_eff = NCH_W'(cfg.channels_in_use);
		end
		priority if (cfg.stride_len == '0) begin
			stride_eff = STRIDE_W'(1);
		end else if (cfg.stride_len > STRIDE_MAX) begin
			stride_eff = STRIDE_MAX;
		end else begin
			stride_eff = cfg.stride_len;
		end
	end

	assign full    = (state_q != FE_IDLE);
	assign accept  = push && !full;
	assign ch_ok   = NCH_W'(in_item.channel) < nch_eff;
	assign is_last = NCH_W'(in_item.channel) == (nch_eff - NCH_W'(1));
	assign slot_d  = ADDR_W'(int'(CIDX_W'(in_item.channel)) * WINDOW_LEN + int'(head_q));

	assign ch_idx   = CIDX_W'(ch_q);
	assign new_prod = sample_q * sample_q;
	assign old_prod = rd_q * rd_q;
	assign cur_sum  = sq_sum_q[ch_idx];
	assign old_ext  = SUM_W'(oldsq_q);
	assign add_sum  = acc_q + SUM_W'(newsq_q);

	assign window_frame = fill_q >= FILL_W'(WINDOW_LEN - 1);
	assign full_win     = fill_q == FILL_W'(WINDOW_LEN);
	assign emit         = window_frame && (phase_q == '0) && (we_q < cfg.max_windows);
	assign phase_inc    = {1'b0, phase_q} + (PHASE_W + 1)'(1);
	assign proceed      = !emit || !job_full;

	assign job_push = (state_q == FE_PUSH) && emit && !job_full;
	assign job_hdr  = '{window_index: we_q, channel_res: ch_q, last_channel: last_q};
	assign job_sum  = cur_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (accept && in_item.kind == KIND_SAMPLE && ch_ok) begin
					state_d = FE_READ;
				end
			end
			FE_READ:   state_d = FE_SQUARE;
			FE_SQUARE: state_d = FE_SUB;
			FE_SUB:    state_d = FE_ADD;
			FE_ADD:    state_d = FE_PUSH;
			FE_PUSH: begin
				if (proceed) begin
					state_d = FE_IDLE;
				end
			end
			default:   state_d = FE_IDLE;
		endcase
	end

	// Item payload and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= in_item.channel;
			last_q   <= is_last;
			sample_q <= in_item.sample;
			slot_q   <= slot_d;
		end
		if (state_q == FE_READ) begin
			newsq_q <= new_prod[30:0];
		end
		if (state_q == FE_SQUARE) begin
			oldsq_q <= old_prod[30:0];
		end
		if (state_q == FE_SUB) begin
			if (full_win) begin
				acc_q <= (cur_sum > old_ext) ? (cur_sum - old_ext) : '0;
			end else begin
				acc_q <= cur_sum;
			end
		end
	end

	// Sample ring: old value read in the cycle before the new one overwrites it
	always_ff @(posedge clk) begin
		if (state_q == FE_READ) begin
			rd_q <= ring_mem[slot_q];
		end
		if (state_q == FE_SQUARE) begin
			ring_mem[slot_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sq_sum_q[i] <= '0;
			end
			head_q  <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			we_q    <= '0;
		end else begin
			if (accept && in_item.kind == KIND_RESTART) begin
				for (int i = 0; i < CHANNELS; i++) begin
					sq_sum_q[i] <= '0;
				end
				head_q  <= '0;
				fill_q  <= '0;
				phase_q <= '0;
				we_q    <= '0;
			end
			if (state_q == FE_ADD) begin
				sq_sum_q[ch_idx] <= (add_sum > SUM_CAP) ? SUM_CAP : add_sum;
			end
			// frame end on the last channel in use
			if (state_q == FE_PUSH && proceed && last_q) begin
				if (emit && we_q != 16'hFFFF) begin
					we_q <= we_q + 16'd1;
				end
				if (window_frame) begin
					phase_q <= (phase_inc >= stride_eff) ? '0 : phase_inc[PHASE_W-1:0];
				end
				if (!full_win) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				head_q <= (head_q == HEAD_W'(WINDOW_LEN - 1)) ? '0 : head_q + HEAD_W'(1);
			end
		end
	end

	`MSR_ASSERT_NXT(a_fe_push_done, job_push, state_q == FE_IDLE, "front end did not return after job push")
	`MSR_ASSERT_IMP(a_fe_fill_sat, 1'b1, fill_q <= FILL_W'(WINDOW_LEN), "fill count beyond window length")
	`MSR_ASSERT_IMP(a_fe_phase_win, phase_q != '0, window_frame, "stride phase moved before window filled")

endmodule

`default_nettype wire

>>> rtl/core/msr_back.sv
// Back end: mean by window length, digit-by-digit square root, result register.
`default_nettype none
`include "multichannel_sliding_rms_defines.svh"

module msr_back #(
	parameter int WINDOW_LEN = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_empty,
	output logic                           job_pop,
	input  msr_pkg::job_hdr_t              job_hdr,
	input  logic [$clog2(WINDOW_LEN)+30:0] job_sum,
	output logic                           empty,
	input  logic                           pop,
	output msr_pkg::out_item_t             out_item
);

	import msr_pkg::*;

	localparam int   LOG_W  = $clog2(WINDOW_LEN);
	localparam int   SUM_W  = LOG_W + 31;
	localparam int   MEAN_W = 31;
	localparam int   REM_W  = LOG_W + 1;
	localparam int   CNT_W  = $clog2(MEAN_W);
	localparam bit   POW2   = ((1 << LOG_W) == WINDOW_LEN);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MEAN_W - 1);
	localparam logic [31:0]      BIT_INIT = 32'h4000_0000;

	be_state_t state_q, state_d;

	job_hdr_t          hdr_q;
	logic [REM_W-1:0]  rem_q;
	logic [MEAN_W-1:0] div_sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       v_q;
	logic [31:0]       root_q;
	logic [31:0]       bit_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [REM_W:0]    div_t;
	logic [REM_W:0]    div_sub;
	logic              div_ge;
	logic [31:0]       sq_rb;
	logic              sq_ge;
	logic              load_out;

	assign div_t   = {rem_q, div_sh_q[MEAN_W-1]};
	assign div_ge  = div_t >= (REM_W + 1)'(WINDOW_LEN);
	assign div_sub = div_t - (REM_W + 1)'(WINDOW_LEN);
	assign sq_rb   = root_q + bit_q;
	assign sq_ge   = v_q >= sq_rb;

	assign job_pop  = (state_q == BE_IDLE) && !job_empty;
	assign load_out = (state_q == BE_DONE) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_IDLE: begin
				if (!job_empty) begin
					state_d = POW2 ? BE_SQRT : BE_DIV;
				end
			end
			BE_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = BE_SQRT;
				end
			end
			BE_SQRT: begin
				if (bit_q[0]) begin
					state_d = BE_DONE;
				end
			end
			BE_DONE: begin
				if (load_out) begin
					state_d = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BE_IDLE: begin
				if (!job_empty) begin
					hdr_q    <= job_hdr;
					rem_q    <= REM_W'(job_sum[SUM_W-1:MEAN_W]);
					div_sh_q <= job_sum[MEAN_W-1:0];
					cnt_q    <= '0;
					// with a power-of-two window the mean is a plain shift
					v_q      <= {1'b0, job_sum[SUM_W-1:LOG_W]};
					root_q   <= '0;
					bit_q    <= BIT_INIT;
				end
			end
			BE_DIV: begin
				// restoring division, quotient bits shift in from the right
				rem_q    <= div_ge ? div_sub[REM_W-1:0] : div_t[REM_W-1:0];
				div_sh_q <= {div_sh_q[MEAN_W-2:0], div_ge};
				v_q      <= {1'b0, div_sh_q[MEAN_W-2:0], div_ge};
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			BE_SQRT: begin
				if (sq_ge) begin
					v_q    <= v_q - sq_rb;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			BE_DONE: begin
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_q <= '{window_index: hdr_q.window_index, channel_res: hdr_q.channel_res,
				rms: root_q[15:0], last_channel: hdr_q.last_channel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	`MSR_ASSERT_IMP(a_be_bit_onehot, state_q == BE_SQRT, $onehot(bit_q), "root bit not one-hot")
	`MSR_ASSERT_IMP(a_be_rem_range, state_q == BE_DIV, rem_q < REM_W'(WINDOW_LEN), "remainder out of range")
	`MSR_ASSERT_IMP(a_be_rms_range, load_out, root_q <= 32'd32768, "rms above full scale")

endmodule

`default_nettype wire

>>> rtl/core/multichannel_sliding_rms.sv
// Top level of the multichannel sliding-window RMS block.
// Usage:
//  Input queue side: drive in_item and raise push; a transaction happens at
//  a clock edge with push high and full low. kind selects sample or restart.
//  Result queue side: while empty is low, out_item holds the oldest result;
//  raise pop to take it. Registers are written through cfg_wr_en, cfg_addr,
//  cfg_wdata while the block is idle.
//  Timing: a sample occupies the front end (full stays high after the
//  transaction until it returns to idle); restart and unused-channel items
//  leave it free. The front end's read-square-subtract-add pass over the ring
//  memory and the sum register file sets that occupancy. Each result is
//  computed in the back end's square-root unit (one root bit a cycle), after
//  a serial divide when WINDOW_LEN is not a power of two.
//  A two-entry job queue sits between front and back; when pop is held low
//  the back end holds its result, the queue fills, and then full rises.
//  Reset clears sums, counters and queues and loads the register defaults;
//  the sample ring is not cleared and needs no clearing pass.
`default_nettype none

module multichannel_sliding_rms #(
	parameter int WINDOW_LEN = 64,
	parameter int CHANNELS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  msr_pkg::in_item_t                   in_item,
	output logic                                empty,
	input  logic                                pop,
	output msr_pkg::out_item_t                  out_item,
	input  logic                                cfg_wr_en,
	input  logic [msr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [msr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	import msr_pkg::*;

	localparam int SUM_W  = $clog2(WINDOW_LEN) + 31;
	localparam int JOB_W  = $bits(job_hdr_t) + SUM_W;

	cfg_t             cfg_q;
	logic             fe_job_push;
	job_hdr_t         fe_job_hdr;
	logic [SUM_W-1:0] fe_job_sum;
	logic             q_full;
	logic             q_empty;
	logic             be_job_pop;
	logic [JOB_W-1:0] q_rd_data;
	job_hdr_t         be_job_hdr;
	logic [SUM_W-1:0] be_job_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{channels_in_use: CHANNELS_IN_USE_RESET,
				stride_len: STRIDE_LEN_RESET, max_windows: MAX_WINDOWS_RESET};
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg_wdata[3:0];
				CFG_STRIDE_LEN:      cfg_q.stride_len      <= cfg_wdata[10:0];
				CFG_MAX_WINDOWS:     cfg_q.max_windows     <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	msr_front #(
		.WINDOW_LEN (WINDOW_LEN),
		.CHANNELS   (CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.job_full (q_full),
		.job_push (fe_job_push),
		.job_hdr  (fe_job_hdr),
		.job_sum  (fe_job_sum)
	);

	msr_fifo #(
		.DATA_W (JOB_W)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_job_push),
		.wr_data ({fe_job_hdr, fe_job_sum}),
		.full    (q_full),
		.rd_en   (be_job_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	assign be_job_hdr = job_hdr_t'(q_rd_data[JOB_W-1:SUM_W]);
	assign be_job_sum = q_rd_data[SUM_W-1:0];

	msr_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job_pop   (be_job_pop),
		.job_hdr   (be_job_hdr),
		.job_sum   (be_job_sum),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_multichannel_sliding_rms.sv
// Self-checking testbench for the multichannel sliding-window RMS block.
`timescale 1ns / 1ps

module tb_multichannel_sliding_rms;
	import msr_pkg::*;

	localparam int WIN_LEN       = 64;
	localparam int N_CHAN        = 8;
	localparam int DRAIN_CYCLES  = 100;
	localparam int STALL_LIMIT   = 4000;
	localparam logic [37:0] SUM_CAP = 38'(WIN_LEN) << 30;

	typedef struct {
		logic               kind;
		logic [2:0]         ch;
		logic signed [15:0] smp;
		int                 frames;   // 0: single transaction, else whole frames
		bit                 typed;
		out_item_t          want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  in_item;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t out_item;
	logic      cfg_wr_en;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// window tracker state
	logic signed [15:0] win_ring [0:N_CHAN*WIN_LEN-1];
	bit                 win_written [0:N_CHAN*WIN_LEN-1];
	logic [36:0]        sq_sum [0:N_CHAN-1];
	logic [5:0]         ring_pos;
	logic [6:0]         frames_seen;
	logic [10:0]        stride_cnt;
	logic [15:0]        win_count;
	logic [3:0]         n_chan_reg    = CHANNELS_IN_USE_RESET;
	logic [10:0]        stride_reg    = STRIDE_LEN_RESET;
	logic [15:0]        win_limit_reg = MAX_WINDOWS_RESET;

	out_item_t rms_due [$];
	out_item_t last_pred;
	bit        last_hit;
	out_item_t head_due;

	int mismatches      = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int settings_used   = 0;
	int idle_cycles     = 0;
	int send_idle       = 0;
	int recv_idle       = 0;
	int calm_left       = 0;

	multichannel_sliding_rms #(
		.WINDOW_LEN(WIN_LEN),
		.CHANNELS  (N_CHAN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned active_channels();
		if (n_chan_reg == 0) return 1;
		if (n_chan_reg > N_CHAN) return N_CHAN;
		return n_chan_reg;
	endfunction

	function automatic int unsigned active_stride();
		if (stride_reg == 0) return 1;
		if (stride_reg > 1024) return 1024;
		return stride_reg;
	endfunction

	// bit-by-bit floor square root
	function automatic logic [15:0] root_floor(input logic [31:0] v);
		logic [15:0] r;
		logic [33:0] t;
		r = '0;
		for (int i = 15; i >= 0; i--) begin
			t = 34'(r | (16'd1 << i));
			if (t * t <= 34'(v))
				r = t[15:0];
		end
		return r;
	endfunction

	function automatic bit unwritten_read(input in_item_t it);
		return it.kind == KIND_SAMPLE && it.channel < active_channels() &&
			frames_seen >= WIN_LEN && !win_written[it.channel * WIN_LEN + ring_pos];
	endfunction

	task automatic step_rms_window(input in_item_t it);
		int unsigned        nch;
		int unsigned        slot;
		logic signed [15:0] smp;
		logic signed [15:0] old_s;
		logic [31:0]        sq;
		logic [37:0]        acc;
		bit                 window_frame;
		bit                 emit;
		out_item_t          res;
		nch = active_channels();
		smp = it.sample;
		last_hit = 1'b0;
		last_pred = '0;
		if (it.kind == KIND_RESTART) begin
			for (int i = 0; i < N_CHAN; i++)
				sq_sum[i] = '0;
			ring_pos = '0;
			frames_seen = '0;
			stride_cnt = '0;
			win_count = '0;
			return;
		end
		if (it.channel >= nch)
			return;
		slot = it.channel * WIN_LEN + ring_pos;
		acc = 38'(sq_sum[it.channel]);
		if (frames_seen >= WIN_LEN) begin
			old_s = win_ring[slot];
			sq = old_s * old_s;
			acc = (acc > 38'(sq)) ? acc - 38'(sq) : '0;
		end
		win_ring[slot] = smp;
		win_written[slot] = 1'b1;
		sq = smp * smp;
		acc = acc + 38'(sq);
		if (acc > SUM_CAP)
			acc = SUM_CAP;
		sq_sum[it.channel] = acc[36:0];

		window_frame = frames_seen >= WIN_LEN - 1;
		emit = window_frame && stride_cnt == 0 && win_count < win_limit_reg;
		if (emit) begin
			res.window_index = win_count;
			res.channel_res  = it.channel;
			res.rms          = root_floor(32'(acc / WIN_LEN));
			res.last_channel = (it.channel == nch - 1);
			rms_due.push_back(res);
			last_pred = res;
			last_hit = 1'b1;
		end

		// the last channel in use closes the frame
		if (it.channel == nch - 1) begin
			if (emit && win_count != 16'hFFFF)
				win_count++;
			if (window_frame) begin
				stride_cnt++;
				if (stride_cnt >= active_stride())
					stride_cnt = '0;
			end
			if (frames_seen < WIN_LEN)
				frames_seen++;
			ring_pos = (ring_pos == WIN_LEN - 1) ? '0 : ring_pos + 6'd1;
		end
	endtask

	task automatic report_mismatch(input string what, input out_item_t want, input out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want idx=%0d ch=%0d rms=%0d last=%0d, got idx=%0d ch=%0d rms=%0d last=%0d",
				what, want.window_index, want.channel_res, want.rms, want.last_channel,
				got.window_index, got.channel_res, got.rms, got.last_channel);
	endtask

	// monitor: register writes, input and result transactions, stall count
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					CFG_CHANNELS_IN_USE: n_chan_reg = cfg_wdata[3:0];
					CFG_STRIDE_LEN:      stride_reg = cfg_wdata[10:0];
					CFG_MAX_WINDOWS:     win_limit_reg = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (rms_due.size() == 0) begin
					report_mismatch("result with nothing pending", '0, out_item);
				end else begin
					head_due = rms_due.pop_front();
					if (out_item.window_index !== head_due.window_index ||
						out_item.channel_res !== head_due.channel_res ||
						out_item.rms !== head_due.rms ||
						out_item.last_channel !== head_due.last_channel)
						report_mismatch("result mismatch", head_due, out_item);
					results_checked++;
				end
			end
			if (push && !full) begin
				step_rms_window(in_item);
				items_sent++;
			end
			if ((pop && !empty) || (push && !full))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk)
		pop <= (calm_left > 0) || ($urandom_range(99) >= recv_idle);

	// entered and left at a falling edge
	task automatic send_item(input in_item_t it);
		if (calm_left > 0)
			calm_left--;
		else if ($urandom_range(63) == 0)
			calm_left = 48;
		while (calm_left == 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!(push && !full));
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// drop push, let pending results drain, then give the front end time to settle
	task automatic wait_idle();
		push <= 1'b0;
		while (rms_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		logic [31:0] rnd;
		rnd = $urandom;
		case ($urandom_range(3))
			0: case (rnd[1:0])
				2'd0: return 16'sh8000;
				2'd1: return 16'sh7FFF;
				2'd2: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
			1: return 16'($signed(rnd[8:0]));
			default: return rnd[15:0];
		endcase
	endfunction

	task automatic run_phase(input logic [15:0] ch_val, input logic [15:0] stride_val,
		input logic [15:0] maxw, input bit restart_first, input int n_items,
		input int noise_pct);
		int          counted;
		int unsigned next_ch;
		int unsigned nch;
		in_item_t    it;
		wait_idle();
		cfg_write(CFG_CHANNELS_IN_USE, ch_val);
		cfg_write(CFG_STRIDE_LEN, stride_val);
		cfg_write(CFG_MAX_WINDOWS, maxw);
		settings_used++;
		next_ch = 0;
		if (restart_first) begin
			it.kind = KIND_RESTART;
			it.channel = 3'($urandom_range(7));
			it.sample = pick_sample();
			send_item(it);
		end
		counted = 0;
		while (counted < n_items) begin
			nch = active_channels();
			it.kind = KIND_SAMPLE;
			it.channel = 3'(next_ch);
			it.sample = pick_sample();
			if ($urandom_range(99) < noise_pct) begin
				it.channel = 3'($urandom_range(7));
				// while filling, a stray frame end would leave ring slots unwritten
				if (frames_seen < WIN_LEN && it.channel == nch - 1)
					it.channel = 3'(next_ch);
				if (nch <= 3 && $urandom_range(9) == 0)
					it.kind = KIND_RESTART;
			end else begin
				next_ch = (next_ch + 1 >= nch) ? 0 : next_ch + 1;
			end
			if (unwritten_read(it))
				it.kind = KIND_RESTART;
			if (it.kind == KIND_RESTART)
				next_ch = 0;
			if (it.kind == KIND_RESTART || it.channel < nch)
				counted++;
			send_item(it);
		end
	endtask

	initial begin
		dir_row_t rows [0:10];
		in_item_t it;
		rows[0]  = '{KIND_RESTART, 3'd5, 16'shFFFF, 0, 1'b0, '0};
		// repeated channel 0 while filling pushes the sum past the cap
		rows[1]  = '{KIND_SAMPLE, 3'd0, 16'sh8000, 0, 1'b0, '0};
		rows[2]  = '{KIND_SAMPLE, 3'd0, 16'sh8000, 63, 1'b0, '0};
		rows[3]  = '{KIND_SAMPLE, 3'd0, 16'sh8000, 1, 1'b1, '{16'd0, 3'd1, 16'd32768, 1'b1}};
		rows[4]  = '{KIND_SAMPLE, 3'd1, 16'sh7FFF, 0, 1'b1, '{16'd1, 3'd1, 16'd32767, 1'b1}};
		rows[5]  = '{KIND_SAMPLE, 3'd2, 16'sh7FFF, 0, 1'b0, '0};
		rows[6]  = '{KIND_SAMPLE, 3'd7, 16'sh8000, 0, 1'b0, '0};
		rows[7]  = '{KIND_SAMPLE, 3'd0, 16'sh0001, 0, 1'b0, '0};
		rows[8]  = '{KIND_SAMPLE, 3'd0, 16'shFFFF, 0, 1'b0, '0};
		rows[9]  = '{KIND_SAMPLE, 3'd1, 16'sh0000, 0, 1'b0, '0};
		rows[10] = '{KIND_RESTART, 3'd0, 16'sh0000, 0, 1'b0, '0};

		for (int i = 0; i < N_CHAN; i++)
			sq_sum[i] = '0;
		ring_pos = '0;
		frames_seen = '0;
		stride_cnt = '0;
		win_count = '0;
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 32;
		recv_idle = 70;
		cfg_write(CFG_CHANNELS_IN_USE, 16'd2);
		cfg_write(CFG_STRIDE_LEN, 16'd1);
		settings_used++;
		for (int r = 0; r < 11; r++) begin
			if (rows[r].frames == 0) begin
				it = '{rows[r].kind, rows[r].ch, rows[r].smp};
				send_item(it);
			end else begin
				for (int f = 0; f < rows[r].frames; f++)
					for (int c = 0; c < int'(active_channels()); c++) begin
						it = '{KIND_SAMPLE, 3'(c), rows[r].smp};
						send_item(it);
					end
			end
			if (rows[r].typed && (!last_hit || last_pred !== rows[r].want))
				report_mismatch("directed row", rows[r].want, last_pred);
		end

		run_phase(16'd1, 16'd1, 16'hFFFF, 1'b1, 150, 5);
		run_phase(16'd3, 16'd2, 16'd5, 1'b1, 300, 4);
		send_idle = 70;
		recv_idle = 32;
		// out-of-range channel count and stride, output disabled
		run_phase(16'd0, 16'd0, 16'd0, 1'b1, 80, 8);
		run_phase(16'd15, 16'd2047, 16'hFFFF, 1'b1, 530, 2);
		send_idle = 0;
		recv_idle = 0;
		// stride shrinks below the running phase, no restart
		run_phase(16'd2, 16'd1, 16'hFFFF, 1'b0, 150, 5);
		wait_idle();

		$display("Run: %0d input transactions, %0d results checked, %0d register settings",
			items_sent, results_checked, settings_used);
		$display("Covered sum cap, repeated and unused channels, restarts, stride wrap, output limit");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> multichannel_sliding_rms.f
+incdir+rtl/core
rtl/core/msr_pkg.sv
rtl/core/msr_fifo.sv
rtl/core/msr_front.sv
rtl/core/msr_back.sv
rtl/core/multichannel_sliding_rms.sv
tb/sv/tb_multichannel_sliding_rms.sv
